FILE: sv/gsa_pkg.sv
package gsa_pkg;

  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int COL_W      = 6;
  localparam int ROW_W      = 8;
  localparam int ROW_CNT_W  = 9;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int PROD_W     = 64;
  localparam int RND_W      = 33;
  localparam int SUM_W      = 34;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ROTATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic [ROW_CNT_W-1:0]  ROWS_RESET = 9'd256;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd64;

  localparam logic signed [DATA_W-1:0] ONE_Q30  = 32'sd1073741824;
  localparam logic signed [PROD_W-1:0] HALF_Q30 = 64'sd536870912;
  localparam logic signed [SUM_W-1:0]  SAT_MAX  = 34'sd2147483647;
  localparam logic signed [SUM_W-1:0]  SAT_MIN  = -34'sd2147483648;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] cos_val;
    logic signed [DATA_W-1:0] sin_val;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     skipped;
    logic                     saturated;
    logic                     bad_index;
  } out_item_t;

  typedef struct packed {
    logic                 capture;
    logic                 wr_en;
    logic                 rd_en;
    logic                 rot_en;
    logic [ROW_CNT_W-1:0] row;
  } dp_cmd_t;

  typedef struct packed {
    logic                     busy;
    logic                     sat;
    logic signed [DATA_W-1:0] rd_data;
  } dp_stat_t;

  // returns {clipped, value}
  function automatic logic [DATA_W:0] clip_sum(input logic signed [SUM_W-1:0] v);
    logic [DATA_W:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, SAT_MAX[DATA_W-1:0]};
    end else if (v < SAT_MIN) begin
      res = {1'b1, SAT_MIN[DATA_W-1:0]};
    end else begin
      res = {1'b0, v[DATA_W-1:0]};
    end
    return res;
  endfunction

endpackage

FILE: sv/gsa_bank.sv
module gsa_bank #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [gsa_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [gsa_pkg::DATA_W-1:0] rdata
);
  import gsa_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/gsa_datapath.sv
module gsa_datapath #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  gsa_pkg::in_item_t  in_data,
  input  gsa_pkg::dp_cmd_t   cmd,
  output gsa_pkg::dp_stat_t  stat
);
  import gsa_pkg::*;

  localparam int BANK_DEPTH = ((MAX_COLS + 1) / 2) * MAX_ROWS;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  function automatic logic [BAW-1:0] addr_of(input logic [COL_W-1:0] idx,
                                              input logic [ROW_CNT_W-1:0] r);
    return BAW'(int'(idx) * MAX_ROWS + int'(r));
  endfunction

  logic [COL_W-1:0]         h;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] c;
  logic signed [DATA_W-1:0] s;

  logic [COL_W-1:0] even_idx;
  logic [COL_W-1:0] odd_idx;

  logic [DATA_W-1:0] even_q;
  logic [DATA_W-1:0] odd_q;

  logic                 v1, v2, v3, rd_pend, sat;
  logic [ROW_CNT_W-1:0] row1, row2, row3;

  logic signed [DATA_W-1:0] x, y;
  logic signed [PROD_W-1:0] pcx, psy, pcy, psx;
  logic signed [PROD_W-1:0] tcx, tsy, tcy, tsx;
  logic signed [RND_W-1:0]  rcx, rsy, rcy, rsx;
  logic signed [SUM_W-1:0]  nx_sum, ny_sum;
  logic [DATA_W:0]          nx_clip, ny_clip;

  logic                 re;
  logic                 even_we, odd_we;
  logic [ROW_CNT_W-1:0] wrow;
  logic [DATA_W-1:0]    even_wdata, odd_wdata;

  assign even_idx = (h >> 1) + COL_W'(h[0]);
  assign odd_idx  = h >> 1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h     <= in_data.col;
      value <= in_data.value;
      c     <= in_data.cos_val;
      s     <= in_data.sin_val;
    end
  end

  assign re   = cmd.rd_en | cmd.rot_en;
  assign wrow = cmd.wr_en ? cmd.row : row3;

  assign even_we    = (cmd.wr_en & ~h[0]) | v3;
  assign odd_we     = (cmd.wr_en & h[0]) | v3;
  assign even_wdata = cmd.wr_en ? value : (h[0] ? ny_clip[DATA_W-1:0] : nx_clip[DATA_W-1:0]);
  assign odd_wdata  = cmd.wr_en ? value : (h[0] ? nx_clip[DATA_W-1:0] : ny_clip[DATA_W-1:0]);

  gsa_bank #(.DEPTH(BANK_DEPTH), .AW(BAW)) u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (addr_of(even_idx, wrow)),
    .wdata (even_wdata),
    .re    (re),
    .raddr (addr_of(even_idx, cmd.row)),
    .rdata (even_q)
  );

  gsa_bank #(.DEPTH(BANK_DEPTH), .AW(BAW)) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (addr_of(odd_idx, wrow)),
    .wdata (odd_wdata),
    .re    (re),
    .raddr (addr_of(odd_idx, cmd.row)),
    .rdata (odd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      v1      <= cmd.rot_en;
      v2      <= v1;
      v3      <= v2;
      rd_pend <= cmd.rd_en;
    end
  end

  assign x = h[0] ? signed'(odd_q) : signed'(even_q);
  assign y = h[0] ? signed'(even_q) : signed'(odd_q);

  always_ff @(posedge clk) begin
    row1 <= cmd.row;
    row2 <= row1;
    row3 <= row2;
    pcx  <= c * x;
    psy  <= s * y;
    pcy  <= c * y;
    psx  <= s * x;
    rcx  <= tcx[PROD_W-2:30];
    rsy  <= tsy[PROD_W-2:30];
    rcy  <= tcy[PROD_W-2:30];
    rsx  <= tsx[PROD_W-2:30];
  end

  assign tcx = pcx + HALF_Q30;
  assign tsy = psy + HALF_Q30;
  assign tcy = pcy + HALF_Q30;
  assign tsx = psx + HALF_Q30;

  assign nx_sum  = SUM_W'(rcx) + SUM_W'(rsy);
  assign ny_sum  = SUM_W'(rcy) - SUM_W'(rsx);
  assign nx_clip = clip_sum(nx_sum);
  assign ny_clip = clip_sum(ny_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (cmd.capture) begin
      sat <= 1'b0;
    end else if (v3 && (nx_clip[DATA_W] || ny_clip[DATA_W])) begin
      sat <= 1'b1;
    end
  end

  assign stat.busy    = v1 | v2 | v3 | rd_pend;
  assign stat.sat     = sat;
  assign stat.rd_data = h[0] ? signed'(odd_q) : signed'(even_q);

endmodule

FILE: sv/gsa_ctrl.sv
module gsa_ctrl #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gsa_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsa_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gsa_pkg::dp_cmd_t                dp_cmd,
  input  gsa_pkg::dp_stat_t               dp_stat
);
  import gsa_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]            state, state_next;
  logic [ROW_CNT_W-1:0]  rows_in_use;
  logic [COLS_CFG_W-1:0] cols_in_use;
  logic [CMD_W-1:0]      cmd_q;
  logic [ROW_W-1:0]      row_q;
  logic                  bad_q, skip_q;
  logic [ROW_CNT_W-1:0]  r, r_next;

  logic accept, row_ok, col_ok, pair_ok, bad_in, skip_in, row_active, out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS: rows_in_use <= cfg_data[ROW_CNT_W-1:0];
        CFG_COLS: cols_in_use <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign row_ok  = ({1'b0, in_data.row} < rows_in_use) && (int'(in_data.row) < MAX_ROWS);
  assign col_ok  = ({1'b0, in_data.col} < cols_in_use) && (int'(in_data.col) < MAX_COLS);
  assign pair_ok = (({1'b0, in_data.col} + 7'd1) < cols_in_use)
                   && (int'(in_data.col) + 1 < MAX_COLS);
  assign bad_in  = (in_data.cmd == CMD_ROTATE) ? ~pair_ok : ~(row_ok & col_ok);
  assign skip_in = (in_data.cmd == CMD_ROTATE) && pair_ok && (in_data.cos_val == ONE_Q30);

  assign row_active = (r < rows_in_use) && (int'(r) < MAX_ROWS);

  assign dp_cmd.capture = accept;
  assign dp_cmd.wr_en   = (state == S_EXEC) && (cmd_q == CMD_LOAD) && ~bad_q;
  assign dp_cmd.rd_en   = (state == S_EXEC) && (cmd_q == CMD_READ) && ~bad_q;
  assign dp_cmd.rot_en  = (state == S_EXEC) && (cmd_q == CMD_ROTATE) && ~bad_q && ~skip_q
                          && row_active;
  assign dp_cmd.row     = (cmd_q == CMD_ROTATE) ? r : {1'b0, row_q};

  always_comb begin
    state_next = state;
    r_next     = r;
    case (state)
      S_IDLE: begin
        r_next = '0;
        if (accept && in_data.cmd != CMD_UNUSED) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_cmd.rot_en) begin
          r_next = r + 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!dp_stat.busy) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= in_data.cmd;
      row_q  <= in_data.row;
      bad_q  <= bad_in;
      skip_q <= skip_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      out_data.data_out  <= (cmd_q == CMD_READ && !bad_q) ? dp_stat.rd_data : '0;
      out_data.skipped   <= skip_q;
      out_data.saturated <= dp_stat.sat;
      out_data.bad_index <= bad_q;
    end
  end

endmodule

FILE: sv/givens_rotation_sequence_apply_unit.sv
// Givens rotation engine over a MAX_ROWS x MAX_COLS matrix of signed Q2.30 entries held in
// two on-chip banks (even and odd columns). Read data returns through the bank's registered
// port. A rotation streams one row per cycle through a read, multiply, round and
// saturate/write-back pipeline; one item is in progress at a time. A bad index, or a rotation
// with a cosine of exactly 1.0, finishes without touching the banks. Every command but the
// unused code returns one result; the next item is taken while a result waits in the output
// register. Entries never loaded read back undefined. Configuration writes are taken every
// cycle and belong in idle periods.
module givens_rotation_sequence_apply_unit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gsa_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gsa_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gsa_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  gsa_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  gsa_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .cmd     (dp_cmd),
    .stat    (dp_stat)
  );

endmodule
